[hdl/ibsp_pkg.sv]
package ibsp_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int SLOT_FIELD_W = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int SUM_W = 11;
	localparam int IN_DATA_W = 48;
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 64;

	localparam logic [7:0] POLL_HEADER = 8'h04;
	localparam logic [15:0] CHECK_BASE = 16'hFFFF;
	localparam logic [7:0] WIDE_TYPE_LOW = 8'h80;
	localparam logic [7:0] WIDE_TYPE_HIGH = 8'h8F;
	localparam logic [7:0] TYPE_FRAME_LEN = 8'h06;
	localparam logic [3:0] CMD_DISCOVER = 4'h8;
	localparam logic [3:0] CMD_TYPE = 4'h9;
	localparam logic [3:0] CMD_VALUE = 4'hA;
	localparam logic [7:0] SLOT_NIBBLE_MASK = 8'h0F;

	localparam logic [1:0] REG_HIGHEST_SLOT = 2'd0;
	localparam logic [1:0] REG_TYPES_LOW = 2'd1;
	localparam logic [1:0] REG_TYPES_HIGH = 2'd2;
	localparam logic [1:0] REG_UNKNOWN_TYPE = 2'd3;
	localparam logic [7:0] UNKNOWN_TYPE_RESET = 8'd253;

	localparam logic INPUT_LINE_BYTE = 1'b0;
	localparam logic INPUT_HOST_WRITE = 1'b1;

	typedef struct packed {
		logic [3:0] highest_slot;
		logic [127:0] slot_types;
		logic [7:0] unknown_type_code;
	} cfg_t;

	// Reply frame as queued: payload bytes, how many, and whether a checksum follows.
	typedef struct packed {
		logic [5:0][7:0] payload;
		logic [2:0] npay;
		logic add_check;
	} desc_t;

endpackage

[hdl/ibsp_front.sv]
module ibsp_front #(
	parameter int SLOT_COUNT = ibsp_pkg::SLOT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic in_user,
	input logic [ibsp_pkg::IN_DATA_W-1:0] in_data,
	input ibsp_pkg::cfg_t cfg,
	output logic push,
	output ibsp_pkg::desc_t push_desc,
	input logic queue_full
);

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [1:0] CNT_IDLE = 2'd0;
	localparam logic [1:0] CNT_CMD = 2'd1;
	localparam logic [1:0] CNT_CHKLO = 2'd2;
	localparam logic [1:0] CNT_CHKHI = 2'd3;

	logic [1:0] byte_count_q;
	logic [7:0] poll1_q;
	logic [7:0] poll2_q;
	logic [31:0] value_store_q [SLOT_COUNT];

	logic accept;
	logic [7:0] line_byte;
	logic [3:0] wr_slot;
	logic [31:0] wr_value;
	logic [15:0] expect_chk;
	logic [15:0] got_chk;
	logic [3:0] cmd;
	logic [3:0] rd_slot;
	logic slot_ok;
	logic [7:0] slot_type;
	logic wide;
	logic [7:0] vlen;
	logic [31:0] value;
	logic reply;

	assign in_ready = !queue_full;
	assign accept = in_valid && in_ready;
	assign line_byte = in_data[7:0];
	assign wr_slot = in_data[11:8];
	assign wr_value = in_data[43:12];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= CNT_IDLE;
			poll1_q <= '0;
			poll2_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				value_store_q[i] <= '0;
			end
		end else if (accept) begin
			if (in_user == ibsp_pkg::INPUT_HOST_WRITE) begin
				if (5'(wr_slot) < 5'(SLOT_COUNT)) begin
					value_store_q[wr_slot[SLOT_W-1:0]] <= wr_value;
				end
			end else begin
				case (byte_count_q)
					CNT_IDLE: begin
						if (line_byte == ibsp_pkg::POLL_HEADER) begin
							byte_count_q <= CNT_CMD;
						end
					end
					CNT_CMD: begin
						poll1_q <= line_byte;
						byte_count_q <= CNT_CHKLO;
					end
					CNT_CHKLO: begin
						poll2_q <= line_byte;
						byte_count_q <= CNT_CHKHI;
					end
					default: begin
						byte_count_q <= CNT_IDLE;
					end
				endcase
			end
		end
	end

	// The header byte is always 0x04, so the sum covers that constant header and the command byte.
	assign expect_chk = 16'(ibsp_pkg::CHECK_BASE - (16'(ibsp_pkg::POLL_HEADER) + 16'(poll1_q)));
	assign got_chk = {line_byte, poll2_q};
	assign cmd = poll1_q[7:4];
	assign rd_slot = poll1_q[3:0];
	assign slot_ok = (rd_slot <= cfg.highest_slot) && (5'(rd_slot) < 5'(SLOT_COUNT));
	assign slot_type = cfg.slot_types[{rd_slot, 3'b000} +: 8];
	assign wide = slot_type inside {[ibsp_pkg::WIDE_TYPE_LOW:ibsp_pkg::WIDE_TYPE_HIGH]};
	assign vlen = wide ? 8'd4 : 8'd2;
	assign value = value_store_q[rd_slot[SLOT_W-1:0]];

	always_comb begin
		reply = 1'b0;
		push_desc = '0;
		case (cmd)
			ibsp_pkg::CMD_DISCOVER: begin
				reply = 1'b1;
				push_desc.payload[0] = ibsp_pkg::POLL_HEADER;
				push_desc.payload[1] = poll1_q;
				push_desc.payload[2] = poll2_q;
				push_desc.payload[3] = line_byte;
				push_desc.npay = 3'd4;
				push_desc.add_check = 1'b0;
			end
			ibsp_pkg::CMD_TYPE: begin
				reply = (slot_type != cfg.unknown_type_code);
				push_desc.payload[0] = ibsp_pkg::TYPE_FRAME_LEN;
				push_desc.payload[1] = poll1_q;
				push_desc.payload[2] = slot_type;
				push_desc.payload[3] = vlen;
				push_desc.npay = 3'd4;
				push_desc.add_check = 1'b1;
			end
			ibsp_pkg::CMD_VALUE: begin
				reply = (slot_type != cfg.unknown_type_code);
				push_desc.payload[0] = 8'(vlen + 8'd4);
				push_desc.payload[1] = poll1_q;
				push_desc.payload[2] = value[7:0];
				push_desc.payload[3] = value[15:8];
				push_desc.payload[4] = wide ? value[23:16] : 8'h00;
				push_desc.payload[5] = wide ? value[31:24] : 8'h00;
				push_desc.npay = wide ? 3'd6 : 3'd4;
				push_desc.add_check = 1'b1;
			end
			default: begin
				reply = 1'b0;
			end
		endcase
	end

	assign push = accept && (in_user == ibsp_pkg::INPUT_LINE_BYTE) &&
		(byte_count_q == CNT_CHKHI) && (expect_chk == got_chk) && slot_ok && reply;

endmodule

[hdl/ibsp_queue.sv]
module ibsp_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input ibsp_pkg::desc_t push_desc,
	output logic full,
	input logic pop,
	output ibsp_pkg::desc_t head,
	output logic empty
);

	localparam int PTR_W = $clog2(ibsp_pkg::QUEUE_DEPTH);

	ibsp_pkg::desc_t entries_q [ibsp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0] count_q;

	assign full = (count_q == (PTR_W+1)'(ibsp_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= (PTR_W+1)'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= (PTR_W+1)'(count_q - 1'b1);
			end
		end
	end

endmodule

[hdl/ibsp_back.sv]
module ibsp_back (
	input logic clk,
	input logic arst_n,
	input ibsp_pkg::desc_t head,
	input logic empty,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_data,
	output logic out_last
);

	logic [2:0] idx_q;
	logic [ibsp_pkg::SUM_W-1:0] sum_q;
	logic out_valid_q;
	logic [7:0] out_data_q;
	logic out_last_q;

	logic load;
	logic in_payload;
	logic [2:0] last_idx;
	logic is_last;
	logic [15:0] chk;
	logic [7:0] next_byte;

	assign load = !empty && (!out_valid_q || out_ready);
	assign in_payload = (idx_q < head.npay);
	assign last_idx = 3'(head.npay - 3'd1 + (head.add_check ? 3'd2 : 3'd0));
	assign is_last = (idx_q == last_idx);
	assign chk = 16'(ibsp_pkg::CHECK_BASE - 16'(sum_q));

	always_comb begin
		if (in_payload) begin
			next_byte = head.payload[idx_q];
		end else if (idx_q == head.npay) begin
			next_byte = chk[7:0];
		end else begin
			next_byte = chk[15:8];
		end
	end

	assign pop = load && is_last;

	// The running sum covers payload bytes only; it is read for both checksum beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (is_last) begin
					idx_q <= '0;
					sum_q <= '0;
				end else begin
					idx_q <= 3'(idx_q + 3'd1);
					if (in_payload) begin
						sum_q <= ibsp_pkg::SUM_W'(sum_q + ibsp_pkg::SUM_W'(next_byte));
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= next_byte;
			out_last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign out_last = out_last_q;

endmodule

[hdl/ibus_sensor_poll_responder.sv]
// Telemetry sensor responder: received bus bytes and host value writes come in on the slave
// stream (tuser 0 = line byte, 1 = host write), reply frames leave one byte per beat on the
// master stream with tlast on the final byte. A new input beat is taken every cycle while the
// four-frame reply queue has room, and a poll's last byte is checked and classified in the same
// cycle that it is accepted. The transmit side sends one reply byte a cycle while m_axis_tready
// is high, so a frame of 4, 6 or 8 bytes goes out as that many beats, and the queue depth sets
// how many polls may be answered ahead of the output. Registers sit on the APB port at byte
// addresses 0, 8, 16 and 24 and must only be written while idle.
module ibus_sensor_poll_responder #(
	parameter int SLOT_COUNT = ibsp_pkg::SLOT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata: line_byte [7:0], slot [11:8], slot_value [43:12], zero [47:44]
	input logic [ibsp_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// tuser: command
	input logic s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// tdata: tx_byte [7:0]
	output logic [7:0] m_axis_tdata,
	output logic m_axis_tlast,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ibsp_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [ibsp_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [ibsp_pkg::CFG_DATA_W-1:0] prdata,
	output logic pready
);

	logic [3:0] highest_slot_q;
	logic [63:0] types_low_q;
	logic [63:0] types_high_q;
	logic [7:0] unknown_type_q;
	logic cfg_write;
	logic [1:0] reg_index;
	ibsp_pkg::cfg_t cfg;

	logic push;
	ibsp_pkg::desc_t push_desc;
	logic queue_full;
	logic pop;
	ibsp_pkg::desc_t head;
	logic queue_empty;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_index = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_slot_q <= '0;
			types_low_q <= '0;
			types_high_q <= '0;
			unknown_type_q <= ibsp_pkg::UNKNOWN_TYPE_RESET;
		end else if (cfg_write) begin
			case (reg_index)
				ibsp_pkg::REG_HIGHEST_SLOT: highest_slot_q <= pwdata[3:0];
				ibsp_pkg::REG_TYPES_LOW: types_low_q <= pwdata;
				ibsp_pkg::REG_TYPES_HIGH: types_high_q <= pwdata;
				ibsp_pkg::REG_UNKNOWN_TYPE: unknown_type_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			ibsp_pkg::REG_HIGHEST_SLOT: prdata = 64'(highest_slot_q);
			ibsp_pkg::REG_TYPES_LOW: prdata = types_low_q;
			ibsp_pkg::REG_TYPES_HIGH: prdata = types_high_q;
			ibsp_pkg::REG_UNKNOWN_TYPE: prdata = 64'(unknown_type_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.highest_slot = highest_slot_q;
	assign cfg.slot_types = {types_high_q, types_low_q};
	assign cfg.unknown_type_code = unknown_type_q;

	ibsp_front #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_user(s_axis_tuser),
		.in_data(s_axis_tdata),
		.cfg(cfg),
		.push(push),
		.push_desc(push_desc),
		.queue_full(queue_full)
	);

	ibsp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_desc(push_desc),
		.full(queue_full),
		.pop(pop),
		.head(head),
		.empty(queue_empty)
	);

	ibsp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(queue_empty),
		.pop(pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data(m_axis_tdata),
		.out_last(m_axis_tlast)
	);

endmodule
